### rtl/core/rwle_pkg.sv
// package for the reader-writer lock entry: codes, transaction types and constants
`default_nettype none
package rwle_pkg;

  localparam int unsigned MaxReaders = 16;
  localparam int unsigned IdW        = 64;
  localparam int unsigned KindW      = 3;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned CountW     = 5;

  typedef enum logic [KindW-1:0] {
    KindQueryRead   = 3'd0,
    KindQueryWrite  = 3'd1,
    KindAcqRead     = 3'd2,
    KindAcqWrite    = 3'd3,
    KindRelRead     = 3'd4,
    KindRelWrite    = 3'd5
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    StatusOk        = 2'd0,
    StatusUnlocked  = 2'd1,
    StatusWrongMode = 2'd2,
    StatusFull      = 2'd3
  } status_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [IdW-1:0]   txn_id;
  } req_t;

  typedef struct packed {
    logic               lockable;
    logic [StatusW-1:0] status;
    logic               write_held;
    logic [CountW-1:0]  reader_count;
  } res_t;

  typedef struct packed {
    logic done;
    logic match;
    logic free;
  } scan_t;

endpackage
`default_nettype wire

### rtl/core/reader_writer_lock_entry.sv
// top level of the reader-writer lock entry: lock state, decision logic and result register
// the result is registered in the exec state, which follows the sweep of every reader id slot
// a new transaction is accepted only once the previous one has finished; the sweep reads the
//   reader id memory through its single read port, one slot per cycle
// reset clears owner, write flag, reader valid bits, count and sequencer at once;
//   the reader id memory is not cleared, a slot's id is only matched where its valid bit is set
// results are strobed for one cycle and cannot be stalled
`default_nettype none
module reader_writer_lock_entry #(
  parameter int unsigned MAX_READERS = rwle_pkg::MaxReaders
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  output      logic           busy_o,
  input  wire rwle_pkg::req_t req_i,
  output      logic           res_valid_o,
  output      rwle_pkg::res_t res_o
);

  localparam int unsigned AW = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
  localparam int unsigned CW = $clog2(MAX_READERS + 1);

  rwle_pkg::req_t           req_q;
  logic [rwle_pkg::IdW-1:0] owner_q, owner_d;
  logic                     write_q, write_d;
  logic [MAX_READERS-1:0]   valid_q, valid_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  rwle_pkg::res_t           res_q, res_d;
  logic                     res_valid_q;

  logic                     busy;
  logic                     accept;
  logic                     mem_re, mem_we;
  logic [AW-1:0]            mem_raddr;
  logic [rwle_pkg::IdW-1:0] mem_rdata;
  rwle_pkg::scan_t          scan;
  logic [AW-1:0]            match_idx, free_idx;
  logic                     is_owner;

  assign accept   = start_i && !busy;
  assign is_owner = (req_q.txn_id == owner_q);

  rwle_scan #(
    .MAX_READERS(MAX_READERS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .txn_i      (req_q.txn_id),
    .valid_i    (valid_q),
    .busy_o     (busy),
    .re_o       (mem_re),
    .raddr_o    (mem_raddr),
    .rdata_i    (mem_rdata),
    .scan_o     (scan),
    .match_idx_o(match_idx),
    .free_idx_o (free_idx)
  );

  rwle_mem #(
    .DEPTH(MAX_READERS)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(free_idx),
    .wdata_i(req_q.txn_id),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    owner_d          = owner_q;
    write_d          = write_q;
    valid_d          = valid_q;
    cnt_d            = cnt_q;
    mem_we           = 1'b0;
    res_d.lockable   = 1'b0;
    res_d.status     = rwle_pkg::StatusOk;
    if (scan.done) begin
      case (req_q.kind)
        rwle_pkg::KindQueryRead: begin
          res_d.lockable = !write_q || is_owner;
        end
        rwle_pkg::KindQueryWrite: begin
          if (write_q) begin
            res_d.lockable = is_owner;
          end else if (cnt_q == '0) begin
            res_d.lockable = 1'b1;
          end else if (cnt_q == CW'(1)) begin
            res_d.lockable = scan.match;
          end else begin
            res_d.lockable = 1'b0;
          end
        end
        rwle_pkg::KindAcqRead: begin
          if (!(write_q && is_owner)) begin
            if (scan.match) begin
              write_d = 1'b0;
            end else if (!scan.free) begin
              res_d.status = rwle_pkg::StatusFull;
            end else begin
              mem_we            = 1'b1;
              valid_d[free_idx] = 1'b1;
              cnt_d             = cnt_q + CW'(1);
              write_d           = 1'b0;
            end
          end
        end
        rwle_pkg::KindAcqWrite: begin
          owner_d = req_q.txn_id;
          write_d = 1'b1;
          valid_d = '0;
          cnt_d   = '0;
        end
        rwle_pkg::KindRelRead: begin
          if (write_q) begin
            if (!is_owner) begin
              res_d.status = rwle_pkg::StatusWrongMode;
            end
          end else if (cnt_q == '0) begin
            res_d.status = rwle_pkg::StatusUnlocked;
          end else if (scan.match) begin
            valid_d[match_idx] = 1'b0;
            cnt_d              = cnt_q - CW'(1);
          end
        end
        rwle_pkg::KindRelWrite: begin
          if (write_q) begin
            write_d = 1'b0;
            owner_d = '0;
            valid_d = '0;
            cnt_d   = '0;
          end else if (cnt_q == '0) begin
            res_d.status = rwle_pkg::StatusUnlocked;
          end else begin
            res_d.status = rwle_pkg::StatusWrongMode;
          end
        end
        default: begin
        end
      endcase
    end
    res_d.write_held   = write_d;
    res_d.reader_count = rwle_pkg::CountW'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q     <= '0;
      write_q     <= 1'b0;
      valid_q     <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      owner_q     <= owner_d;
      write_q     <= write_d;
      valid_q     <= valid_d;
      cnt_q       <= cnt_d;
      res_valid_q <= scan.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (scan.done) begin
      res_q <= res_d;
    end
  end

  assign busy_o      = busy;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == CW'($countones(valid_q)))
    else $error("reader count disagrees with valid bits");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(write_q && (cnt_q != '0)))
    else $error("write lock held while readers present");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("id memory written during the sweep");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy_o)
    else $error("result strobed while a transaction is in flight");

endmodule
`default_nettype wire

### rtl/core/rwle_mem.sv
// reader id memory, one write port and one registered read port
`default_nettype none
module rwle_mem #(
  parameter int unsigned DEPTH = rwle_pkg::MaxReaders,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [AW-1:0]            waddr_i,
  input  wire logic [rwle_pkg::IdW-1:0] wdata_i,
  input  wire logic                     re_i,
  input  wire logic [AW-1:0]            raddr_i,
  output      logic [rwle_pkg::IdW-1:0] rdata_o
);

  logic [rwle_pkg::IdW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### rtl/core/rwle_scan.sv
// sweep sequencer: reads every reader slot, finds the matching id and the lowest free slot
`default_nettype none
module rwle_scan #(
  parameter int unsigned MAX_READERS = rwle_pkg::MaxReaders,
  localparam int unsigned AW = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1,
  localparam int unsigned CW = $clog2(MAX_READERS + 1)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [rwle_pkg::IdW-1:0] txn_i,
  input  wire logic [MAX_READERS-1:0]   valid_i,
  output      logic                     busy_o,
  output      logic                     re_o,
  output      logic [AW-1:0]            raddr_o,
  input  wire logic [rwle_pkg::IdW-1:0] rdata_i,
  output      rwle_pkg::scan_t          scan_o,
  output      logic [AW-1:0]            match_idx_o,
  output      logic [AW-1:0]            free_idx_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StExec = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          cmp_vld_q;
  logic [AW-1:0] addr_q;
  logic          match_q, match_d;
  logic          free_q, free_d;
  logic [AW-1:0] match_idx_q, match_idx_d;
  logic [AW-1:0] free_idx_q, free_idx_d;
  logic          slot_vld;
  logic          last;

  assign last     = (idx_q == CW'(MAX_READERS));
  assign re_o     = (state_q == StScan) && !last;
  assign raddr_o  = idx_q[AW-1:0];
  assign slot_vld = valid_i[addr_q];

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    match_d     = match_q;
    free_d      = free_q;
    match_idx_d = match_idx_q;
    free_idx_d  = free_idx_q;
    if (cmp_vld_q) begin
      if (slot_vld && (rdata_i == txn_i) && !match_q) begin
        match_d     = 1'b1;
        match_idx_d = addr_q;
      end
      if (!slot_vld && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = addr_q;
      end
    end
    case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StScan;
          idx_d   = '0;
          match_d = 1'b0;
          free_d  = 1'b0;
        end
      end
      StScan: begin
        if (last) begin
          state_d = StExec;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      StExec: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      match_q   <= 1'b0;
      free_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      cmp_vld_q <= re_o;
      match_q   <= match_d;
      free_q    <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q      <= raddr_o;
    match_idx_q <= match_idx_d;
    free_idx_q  <= free_idx_d;
  end

  assign busy_o       = (state_q != StIdle);
  assign scan_o.done  = (state_q == StExec);
  assign scan_o.match = match_q;
  assign scan_o.free  = free_q;
  assign match_idx_o  = match_idx_q;
  assign free_idx_o   = free_idx_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StExec) |-> $past(last))
    else $error("exec entered before the sweep finished");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !cmp_vld_q)
    else $error("slot compare pending while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= CW'(MAX_READERS))
    else $error("sweep index past the last slot");

endmodule
`default_nettype wire
